// ----- design/rppg_pkg.sv -----
// Package for the rainbow phase pixel generator: payload types, codes, constants, functions.
`timescale 1ns / 1ps
`default_nettype none
package rppg_pkg;

    localparam int WIDTH        = 16;
    localparam int HEIGHT       = 16;
    localparam int PHASE_W      = 11;
    localparam int PHASE_PERIOD = 1536;
    localparam int ADDR_W       = 8;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int CRD_W        = 7;
    localparam int PROD_W       = 12;
    localparam int SUM_W        = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int SPEED_W      = 6;
    localparam int ZOOM_W       = 8;

    typedef enum logic [0:0] {
        ACT_ADVANCE = 1'b0,
        ACT_REPHASE = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED  = 2'd0,
        CFG_ZOOM   = 2'd1,
        CFG_OFFSET = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_action    action;
        logic [3:0] col;
        logic [3:0] row;
    } t_in_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_req;

    // x mod 1536 for x < 6144: 1536 = 3 * 512, so reduce the upper bits mod 3
    function automatic logic [PHASE_W-1:0] phase_mod(input logic [SUM_W-1:0] x);
        logic [3:0] q;
        logic [1:0] r;
        q = x[SUM_W-1:9];
        case (q)
            4'd0, 4'd3, 4'd6, 4'd9:  r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
            default:                 r = 2'd2;
        endcase
        return {r, x[8:0]};
    endfunction

endpackage
`default_nettype wire

// ----- design/rainbow_phase_pixel_generator.sv -----
// Top level of the rainbow phase pixel generator: phase memory, update pipe, output register.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one request per cycle while o_in_stall is low. A request reads its pixel's phase
// from a 256 x 11 memory into a read register; the update stage then computes the new
// phase, writes it back and forwards it to a request for the same pixel that follows
// directly. Advance requests give a color through an output register; rephase requests
// and requests with coordinates outside the panel give nothing. Phases are undefined until
// a rephase writes them; the memory has no clearing pass. Registers must be written only
// while the block is idle; the block itself does not enforce this.
module rainbow_phase_pixel_generator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rppg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rppg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    input  wire rppg_pkg::t_in_req                  i_in_req,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output rppg_pkg::t_out_req                      o_out_req,
    input  wire logic                               i_out_stall
);
    import rppg_pkg::*;

    logic [SPEED_W-1:0]    r_speed;
    logic [ZOOM_W-1:0]     r_zoom;
    logic [PHASE_W-1:0]    r_offset;

    logic [PHASE_W-1:0]    r_phase_mem [STORE_DEPTH];
    logic [PHASE_W-1:0]    r_rd;

    logic                  r_s1_valid;
    t_action               r_s1_action;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic [PROD_W-1:0]     r_s1_prod;

    logic                  r_fwd_valid;
    logic [ADDR_W-1:0]     r_fwd_addr;
    logic [PHASE_W-1:0]    r_fwd_data;

    logic                  r_out_valid;
    t_out_req              r_out_req;

    logic                  w_in_ok;
    logic                  w_in_acc;
    logic                  w_load;
    logic [PROD_W-1:0]     w_lin;
    logic [ADDR_W-1:0]     w_addr;
    logic                  w_out_free;
    logic                  w_s1_done;
    logic                  w_mem_we;
    logic [PHASE_W-1:0]    w_base;
    logic [PROD_W-1:0]     w_adv_sum;
    logic [PROD_W-1:0]     w_adv_wrap;
    logic [PHASE_W-1:0]    n_phase;
    t_rgb                  w_rgb;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SPEED_W'(1);
            r_zoom   <= ZOOM_W'(1);
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPEED:  r_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_ZOOM:   r_zoom   <= i_cfg_data[ZOOM_W-1:0];
                CFG_OFFSET: r_offset <= i_cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and stage control
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_done  = r_s1_valid && ((r_s1_action == ACT_REPHASE) || w_out_free);
    assign o_in_stall = r_s1_valid && !w_s1_done;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_in_ok = ({3'b000, i_in_req.col} < CRD_W'(WIDTH))
                  && ({3'b000, i_in_req.row} < CRD_W'(HEIGHT));
    assign w_lin   = PROD_W'(i_in_req.row) * PROD_W'(WIDTH) + PROD_W'(i_in_req.col);
    assign w_addr  = w_lin[ADDR_W-1:0];
    assign w_load  = w_in_acc && w_in_ok;

    // read stage
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rd <= r_phase_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_action <= i_in_req.action;
            r_s1_addr   <= w_addr;
            r_s1_prod   <= PROD_W'(i_in_req.row) * PROD_W'(r_zoom);
        end
    end

    // update stage: modify with forwarding of the last write
    assign w_base = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rd;
    assign w_adv_sum  = PROD_W'(w_base) + PROD_W'(r_speed);
    assign w_adv_wrap = (w_adv_sum >= PROD_W'(PHASE_PERIOD))
                      ? w_adv_sum - PROD_W'(PHASE_PERIOD) : w_adv_sum;

    always_comb begin
        unique case (r_s1_action)
            ACT_REPHASE: n_phase = phase_mod(SUM_W'(r_offset) + SUM_W'(r_s1_prod));
            ACT_ADVANCE: n_phase = w_adv_wrap[PHASE_W-1:0];
        endcase
    end

    assign w_mem_we = w_s1_done;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_phase_mem[r_s1_addr] <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (w_mem_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_phase;
        end
    end

    rppg_hue u_hue (
        .i_phase (n_phase),
        .o_rgb   (w_rgb)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_done && (r_s1_action == ACT_ADVANCE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_done && (r_s1_action == ACT_ADVANCE)) begin
            r_out_req <= '{pixel_index: r_s1_addr, red: w_rgb.red,
                           green: w_rgb.green, blue: w_rgb.blue};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (n_phase < PHASE_W'(PHASE_PERIOD)))
        else $error("phase written out of range");

    a_advance_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && (r_s1_action == ACT_ADVANCE))
            |=> (r_out_valid && (r_out_req.pixel_index == $past(r_s1_addr))))
        else $error("advance did not reach the output register");

    a_rephase_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && (r_s1_action == ACT_REPHASE) && !r_out_valid) |=> !r_out_valid)
        else $error("rephase produced a result");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with an empty pipe");

endmodule
`default_nettype wire

// ----- design/rppg_hue.sv -----
// Six-segment hue wheel: phase to 8-bit RGB.
`timescale 1ns / 1ps
`default_nettype none
module rppg_hue (
    input  wire logic [rppg_pkg::PHASE_W-1:0] i_phase,
    output rppg_pkg::t_rgb                    o_rgb
);
    import rppg_pkg::*;

    logic [7:0] w_i;
    logic [7:0] w_inv;

    assign w_i   = i_phase[7:0];
    assign w_inv = ~w_i;

    always_comb begin
        case (i_phase[PHASE_W-1:8])
            3'd0: begin
                o_rgb = '{red: 8'hFF, green: w_i, blue: 8'h00};
            end
            3'd1: begin
                o_rgb = '{red: w_inv, green: 8'hFF, blue: 8'h00};
            end
            3'd2: begin
                o_rgb = '{red: 8'h00, green: 8'hFF, blue: w_i};
            end
            3'd3: begin
                o_rgb = '{red: 8'h00, green: w_inv, blue: 8'hFF};
            end
            3'd4: begin
                o_rgb = '{red: w_i, green: 8'h00, blue: 8'hFF};
            end
            default: begin
                o_rgb = '{red: 8'hFF, green: 8'h00, blue: w_inv};
            end
        endcase
    end

endmodule
`default_nettype wire
